@@ rtl/core/rab_pkg.sv @@
// Shared types and constants for the rotated area blit address engine.
package rab_pkg;

  localparam int COORD_W = 16;
  localparam int PIX_W   = 32;
  localparam int IDX_W   = 20;

  localparam int S_DATA_W = 4 * COORD_W + PIX_W;
  localparam int M_DATA_W = ((IDX_W + PIX_W + 7) / 8) * 8;
  localparam int M_USER_W = 2;

  localparam int DEF_LOGICAL_WIDTH  = 1280;
  localparam int DEF_LOGICAL_HEIGHT = 720;
  localparam int DEF_FB_STRIDE      = 720;

  typedef enum logic {
    OP_AREA  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef struct packed {
    logic area_rejected;
    logic write_valid;
  } out_flags_t;

endpackage

@@ rtl/core/rotated_area_blit_address.sv @@
// Rotating blit address engine: clamps a dirty area and maps its pixels to framebuffer indices.
//
// Input words (s_axis): tuser is the opcode. An area word clamps its corners to the
// logical screen; an empty area gives one output word with tlast and the rejected
// flag set, otherwise the row and column counters are armed and nothing is sent.
// A pixel word while armed gives one output word holding the pixel and its index
// (LOGICAL_WIDTH-1-x)*FB_STRIDE + y, scanned row-major over the area; the last
// pixel carries tlast and disarms. Pixels while disarmed are dropped.
// The output word is registered: it is valid in the cycle after input accept. One word is
// taken each cycle while the output is not stalled; the constant-stride multiply and the
// counter update share that cycle, between the counter registers and the output register.
// When the receiver stalls, the output register holds its word and s_axis_tready
// drops only while that word is still unread; a word can be taken in the cycle
// the held word leaves.
// Reset disarms the engine and empties the output register.
module rotated_area_blit_address
  import rab_pkg::*;
#(
  parameter int LOGICAL_WIDTH  = DEF_LOGICAL_WIDTH,
  parameter int LOGICAL_HEIGHT = DEF_LOGICAL_HEIGHT,
  parameter int FB_STRIDE      = DEF_FB_STRIDE
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // area_left, area_top, area_right, area_bottom, pixel_in
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // opcode
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // write_index, pixel_out, zero fill
  output logic [M_DATA_W-1:0] m_axis_tdata,
  // write_valid, area_rejected
  output logic [M_USER_W-1:0] m_axis_tuser,
  // area_done
  output logic                m_axis_tlast
);

  localparam int COL_W = $clog2(LOGICAL_WIDTH);
  localparam int ROW_W = $clog2(LOGICAL_HEIGHT);
  localparam int STR_W = $clog2(FB_STRIDE + 1);
  localparam int PROD_W = COL_W + STR_W + 1;
  localparam int SUM_W = (PROD_W > IDX_W) ? PROD_W : IDX_W;
  localparam logic signed [COORD_W-1:0] X_MAX = COORD_W'(LOGICAL_WIDTH - 1);
  localparam logic signed [COORD_W-1:0] Y_MAX = COORD_W'(LOGICAL_HEIGHT - 1);

  logic             armed;
  logic [COL_W-1:0] col_now;
  logic [ROW_W-1:0] row_now;
  logic [COL_W-1:0] col_first;
  logic [COL_W-1:0] col_last;
  logic [ROW_W-1:0] row_last;

  logic                out_valid;
  logic [M_DATA_W-1:0] out_data;
  out_flags_t          out_flags;
  logic                out_last;

  logic in_accept;
  opcode_t op;
  logic signed [COORD_W-1:0] area_left, area_top, area_right, area_bottom;
  logic signed [COORD_W-1:0] l_clamp, t_clamp, r_clamp, b_clamp;
  logic [PIX_W-1:0] pixel_in;
  logic             reject;
  logic             col_end, row_end;
  logic [COL_W-1:0] flipped;
  logic [SUM_W-1:0] idx_full;
  logic [IDX_W-1:0] write_index;

  logic                out_valid_next;
  logic [M_DATA_W-1:0] out_data_next;
  out_flags_t          out_flags_next;
  logic                out_last_next;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign op          = opcode_t'(s_axis_tuser);
  assign area_left   = s_axis_tdata[0*COORD_W +: COORD_W];
  assign area_top    = s_axis_tdata[1*COORD_W +: COORD_W];
  assign area_right  = s_axis_tdata[2*COORD_W +: COORD_W];
  assign area_bottom = s_axis_tdata[3*COORD_W +: COORD_W];
  assign pixel_in    = s_axis_tdata[4*COORD_W +: PIX_W];

  always_comb begin
    l_clamp = area_left;
    t_clamp = area_top;
    r_clamp = area_right;
    b_clamp = area_bottom;
    if (area_left[COORD_W-1]) l_clamp = '0;
    if (area_top[COORD_W-1])  t_clamp = '0;
    if (area_right > X_MAX)   r_clamp = X_MAX;
    if (area_bottom > Y_MAX)  b_clamp = Y_MAX;
  end

  assign reject = (l_clamp > r_clamp) || (t_clamp > b_clamp);

  assign col_end = (col_now == col_last);
  assign row_end = (row_now == row_last);

  assign flipped     = COL_W'(LOGICAL_WIDTH - 1) - col_now;
  assign idx_full    = SUM_W'(flipped) * SUM_W'(FB_STRIDE) + SUM_W'(row_now);
  assign write_index = idx_full[IDX_W-1:0];

  always_comb begin
    out_valid_next = 1'b0;
    out_data_next  = '0;
    out_flags_next = '0;
    out_last_next  = 1'b0;
    if (op == OP_AREA) begin
      if (reject) begin
        out_valid_next               = 1'b1;
        out_last_next                = 1'b1;
        out_flags_next.area_rejected = 1'b1;
      end
    end else if (armed) begin
      out_valid_next             = 1'b1;
      out_flags_next.write_valid = 1'b1;
      out_last_next              = col_end && row_end;
      out_data_next              = M_DATA_W'({pixel_in, write_index});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      col_now   <= '0;
      row_now   <= '0;
      col_first <= '0;
      col_last  <= '0;
      row_last  <= '0;
    end else if (in_accept) begin
      if (op == OP_AREA) begin
        armed <= !reject;
        if (!reject) begin
          col_first <= l_clamp[COL_W-1:0];
          col_now   <= l_clamp[COL_W-1:0];
          col_last  <= r_clamp[COL_W-1:0];
          row_now   <= t_clamp[ROW_W-1:0];
          row_last  <= b_clamp[ROW_W-1:0];
        end
      end else if (armed) begin
        if (col_end) begin
          col_now <= col_first;
          if (row_end) begin
            armed <= 1'b0;
          end else begin
            row_now <= row_now + ROW_W'(1);
          end
        end else begin
          col_now <= col_now + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid <= in_accept && out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data  <= out_data_next;
      out_flags <= out_flags_next;
      out_last  <= out_last_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_flags;
  assign m_axis_tlast  = out_last;

  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("rejected area word must be done and carry no write");

  a_counters_in_area: assert property (@(posedge clk) disable iff (rst)
    armed |-> col_now >= col_first && col_now <= col_last && row_now <= row_last)
    else $error("armed counters outside the clamped area");

  a_drop_idle_pixel: assert property (@(posedge clk) disable iff (rst)
    in_accept && op == OP_PIXEL && !armed |=> !m_axis_tvalid)
    else $error("pixel while disarmed produced a word");

  a_last_disarms: assert property (@(posedge clk) disable iff (rst)
    in_accept && op == OP_PIXEL && armed && col_end && row_end |=> !armed && m_axis_tlast)
    else $error("last pixel did not disarm and mark done");

endmodule
